// ===== design/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared constants, register indexes and region tables for the stress trend
// region ladder.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int RING_DEPTH_DEF = 8;

  localparam int SAMPLE_W = 8;
  localparam int THR_W    = 8;
  localparam int BAND_W   = 9;
  localparam int REGION_W = 4;
  localparam int AVG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [THR_W-1:0]         JUMP_THR_RST   = 8'd25;
  localparam logic signed [BAND_W-1:0] BAND_UPPER_RST = 9'sd5;
  localparam logic signed [BAND_W-1:0] BAND_LOWER_RST = -9'sd5;

  localparam logic [REGION_W-1:0] REGION_TOP    = 4'd9;
  localparam logic [REGION_W-1:0] REGION_BOTTOM = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_THR   = 2'd0,
    CFG_BAND_UPPER = 2'd1,
    CFG_BAND_LOWER = 2'd2
  } cfg_idx_t;

  function automatic logic [7:0] region_freq(input logic [REGION_W-1:0] region);
    logic [7:0] f;
    case (region)
      4'd1:    f = 8'd20;
      4'd2:    f = 8'd35;
      4'd3:    f = 8'd50;
      4'd4:    f = 8'd50;
      4'd5:    f = 8'd50;
      4'd6:    f = 8'd65;
      4'd7:    f = 8'd65;
      4'd8:    f = 8'd65;
      default: f = 8'd80;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] region_amp(input logic [REGION_W-1:0] region);
    logic [7:0] a;
    case (region)
      4'd1:    a = 8'd10;
      4'd2:    a = 8'd10;
      4'd3:    a = 8'd10;
      4'd4:    a = 8'd20;
      4'd5:    a = 8'd30;
      4'd6:    a = 8'd30;
      4'd7:    a = 8'd40;
      4'd8:    a = 8'd50;
      default: a = 8'd50;
    endcase
    return a;
  endfunction

endpackage

// ===== design/stl_ram.sv =====
// ----------------------------------------------------------------------------
// stl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/stl_div.sv =====
// ----------------------------------------------------------------------------
// stl_div
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module stl_div #(
  parameter int NUM_W = 11,
  parameter int DEN_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in DEN_W bits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/stress_trend_region_ladder_top.sv =====
// ----------------------------------------------------------------------------
// stress_trend_region_ladder_top
// Heart-rate trend tracker that walks a sample ring and moves a stress region.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_heart_sample): one sample byte per
// transaction, written into the ring RAM at the wrapping write pointer.
// Result channel (out_valid / out_stall / out_*): at most one transaction per
// sample, holding region frequency, amplitude, region number, moved flag and
// the averaged change. Config channel (cfg_valid / cfg_ready / cfg_index /
// cfg_data) is always ready; unknown indexes are dropped.
// One sample at a time: after acceptance the ring RAM is read one entry per
// cycle, then the bit-serial divider averages the change and a decision
// state sets the region. A sample with no counted pair or a zero average
// returns to idle with no result. The result is registered at the decision,
// and the block then returns to idle and accepts the next sample; the work
// is set by the single RAM read port walk and the bit-serial divider.
// in_stall is high during that work.
// The output register holds a result while out_stall is high; the next sample
// is still accepted and processed, and waits only at its own decision.
// Reset empties the ring (per-entry valid bits), zeroes the pointer and sets
// the region to 9 and the registers to their defaults.
// ----------------------------------------------------------------------------
module stress_trend_region_ladder_top
  import stl_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_heart_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_freq,
  output logic [7:0]            out_amp,
  output logic [REGION_W-1:0]   out_region_now,
  output logic                  out_moved,
  output logic signed [AVG_W-1:0] out_avg_change,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int IW    = $clog2(RING_DEPTH + 1);
  localparam int CNT_W = $clog2(RING_DEPTH);
  localparam int MAG_W = $clog2((RING_DEPTH - 1) * 255 + 1);
  localparam int SUM_W = MAG_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [RING_DEPTH-1:0]   valid_r, valid_nxt;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [REGION_W-1:0]     region_r, region_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [SAMPLE_W-1:0]     prev_r, prev_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [AVG_W-1:0] avg_r, avg_nxt;

  logic [THR_W-1:0]         jump_thr_r;
  logic signed [BAND_W-1:0] band_upper_r;
  logic signed [BAND_W-1:0] band_lower_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_freq_r, out_freq_nxt;
  logic [7:0]              out_amp_r, out_amp_nxt;
  logic [REGION_W-1:0]     out_region_r, out_region_nxt;
  logic                    out_moved_r, out_moved_nxt;
  logic signed [AVG_W-1:0] out_avg_r, out_avg_nxt;

  logic                    ram_we;
  logic [SAMPLE_W-1:0]     ram_rdata;
  logic [SAMPLE_W-1:0]     cur;
  logic signed [SAMPLE_W:0] diff;
  logic [SUM_W-1:0]        sum_abs;
  logic                    div_start;
  logic                    div_done;
  logic [MAG_W-1:0]        div_quo;
  logic [AVG_W-1:0]        avg_mag;
  logic                    do_jump;
  logic                    in_band;
  logic                    moved;

  stl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_heart_sample),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  stl_div #(
    .NUM_W (MAG_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_abs[MAG_W-1:0]),
    .divisor  (count_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // entries never written since the last clear read as empty
  assign cur  = ram_rdata & {SAMPLE_W{rd_vld_r}};
  assign diff = $signed({1'b0, cur}) - $signed({1'b0, prev_r});

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    wp_nxt         = wp_r;
    region_nxt     = region_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    prev_nxt       = prev_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    neg_nxt        = neg_r;
    avg_nxt        = avg_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_freq_nxt   = out_freq_r;
    out_amp_nxt    = out_amp_r;
    out_region_nxt = out_region_r;
    out_moved_nxt  = out_moved_r;
    out_avg_nxt    = out_avg_r;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    sum_abs        = '0;
    avg_mag        = {1'b0, div_quo[7:0]};
    do_jump        = ($signed({avg_r[AVG_W-1], avg_r}) >= $signed({2'b00, jump_thr_r}));
    in_band        = (avg_r > band_lower_r) && (avg_r < band_upper_r);
    moved          = do_jump || in_band;

    if (idx_r < IW'(RING_DEPTH)) begin
      rd_vld_nxt = valid_r[idx_r[AW-1:0]];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ram_we          = 1'b1;
          valid_nxt[wp_r] = 1'b1;
          wp_nxt    = (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          idx_nxt   = '0;
          prev_nxt  = '0;
          sum_nxt   = '0;
          count_nxt = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r != '0) begin
          prev_nxt = cur;
          // pairs are array-adjacent, no wrap from last entry to first
          if (idx_r >= IW'(2) && cur != '0 && prev_r != '0) begin
            sum_nxt   = sum_r + SUM_W'(diff);
            count_nxt = count_r + 1'b1;
          end
        end
        sum_abs = sum_nxt[SUM_W-1] ? -sum_nxt : sum_nxt;
        neg_nxt = sum_nxt[SUM_W-1];
        if (idx_r == IW'(RING_DEPTH)) begin
          if (count_nxt == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_nxt = neg_r ? -avg_mag : avg_mag;
          if (div_quo == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (do_jump) begin
            region_nxt = REGION_TOP;
          end else if (in_band && region_r > REGION_BOTTOM) begin
            region_nxt = region_r - 1'b1;
          end
          if (moved) begin
            valid_nxt = '0;
          end
          out_valid_nxt  = 1'b1;
          out_freq_nxt   = region_freq(region_nxt);
          out_amp_nxt    = region_amp(region_nxt);
          out_region_nxt = region_nxt;
          out_moved_nxt  = moved;
          out_avg_nxt    = avg_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      wp_r         <= '0;
      region_r     <= REGION_TOP;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      jump_thr_r   <= JUMP_THR_RST;
      band_upper_r <= BAND_UPPER_RST;
      band_lower_r <= BAND_LOWER_RST;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      wp_r        <= wp_nxt;
      region_r    <= region_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_JUMP_THR:   jump_thr_r   <= cfg_data[THR_W-1:0];
          CFG_BAND_UPPER: band_upper_r <= $signed(cfg_data);
          CFG_BAND_LOWER: band_lower_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
    prev_r       <= prev_nxt;
    sum_r        <= sum_nxt;
    count_r      <= count_nxt;
    neg_r        <= neg_nxt;
    avg_r        <= avg_nxt;
    out_freq_r   <= out_freq_nxt;
    out_amp_r    <= out_amp_nxt;
    out_region_r <= out_region_nxt;
    out_moved_r  <= out_moved_nxt;
    out_avg_r    <= out_avg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_freq       = out_freq_r;
  assign out_amp        = out_amp_r;
  assign out_region_now = out_region_r;
  assign out_moved      = out_moved_r;
  assign out_avg_change = out_avg_r;

endmodule
